// ===== rtl/gdt2_pkg.sv =====
package gdt2_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int FRAC_BITS  = 16;

  localparam int MAX_LINE  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int MAP_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int MAP_AW    = $clog2(MAP_DEPTH);
  localparam int CNT_W     = $clog2(MAP_DEPTH + 1);
  localparam int IDX_W     = $clog2(MAX_LINE);
  localparam int DIM_W     = $clog2(MAX_LINE + 1);
  localparam int D_W       = IDX_W + 1;

  localparam int SCORE_W = 32;
  localparam int VAL_W   = 48;
  localparam int COEF_W  = 32;
  localparam int QUAD_W  = 31;
  localparam int CFG_W   = 32;
  localparam int CFG_AW  = 3;
  localparam int FIELD_W = 7;

  localparam int BOUND_W = FRAC_BITS + $clog2(MAX_LINE + 2) + 1;
  localparam int SQ_W    = 2 * IDX_W;
  localparam int P1_W    = QUAD_W + SQ_W;
  localparam int P2_W    = COEF_W + D_W;
  localparam int NUM_W   = VAL_W + 3;
  localparam int DEN_W   = QUAD_W + D_W + 1;
  localparam int LDEN_W  = DEN_W + DIM_W;
  localparam int QUOT_W  = FRAC_BITS + DIM_W;
  localparam int DIV_W   = LDEN_W + FRAC_BITS;
  localparam int QCNT_W  = $clog2(QUOT_W);

  localparam int QUEUE_DEPTH = 4;
  localparam int Q_AW        = $clog2(QUEUE_DEPTH);

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_READ = 1'b1;

  localparam logic [CFG_AW-1:0] REG_WIDTH_IN_USE  = 3'd0;
  localparam logic [CFG_AW-1:0] REG_HEIGHT_IN_USE = 3'd1;
  localparam logic [CFG_AW-1:0] REG_X_QUAD        = 3'd2;
  localparam logic [CFG_AW-1:0] REG_X_LINEAR      = 3'd3;
  localparam logic [CFG_AW-1:0] REG_X_CONST       = 3'd4;
  localparam logic [CFG_AW-1:0] REG_Y_QUAD        = 3'd5;
  localparam logic [CFG_AW-1:0] REG_Y_LINEAR      = 3'd6;
  localparam logic [CFG_AW-1:0] REG_Y_CONST       = 3'd7;

  typedef struct packed {
    logic                      mode;
    logic signed [SCORE_W-1:0] score;
  } gdt2_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [FIELD_W-1:0]      col_index;
    logic [FIELD_W-1:0]      row_index;
    logic                    last;
  } gdt2_out_t;

  typedef struct packed {
    logic                is_read;
    logic                flag;
    logic [MAP_AW-1:0]   addr;
    logic [IDX_W-1:0]    row;
    logic [SCORE_W-1:0]  score;
  } gdt2_cmd_t;

  typedef struct packed {
    logic [QUAD_W-1:0]        quad;
    logic signed [COEF_W-1:0] linear;
    logic signed [COEF_W-1:0] offset;
  } gdt2_axis_t;

  typedef struct packed {
    logic [IDX_W-1:0]          idx;
    logic signed [VAL_W-1:0]   value;
  } gdt2_ent_t;

  typedef struct packed {
    logic [IDX_W-1:0]          vertex;
    logic signed [BOUND_W-1:0] bound;
  } gdt2_env_t;

endpackage

// ===== rtl/gdt2_ram.sv =====
module gdt2_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/gdt2_queue.sv =====
module gdt2_queue import gdt2_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  gdt2_cmd_t push_cmd,
  input  logic      pop,
  output logic      empty,
  output logic      full,
  output gdt2_cmd_t head
);

  gdt2_cmd_t       slots [QUEUE_DEPTH];
  logic [Q_AW-1:0] wp;
  logic [Q_AW-1:0] rp;
  logic [Q_AW:0]   count;

  assign empty = (count == '0);
  assign full  = (count == (Q_AW+1)'(QUEUE_DEPTH));
  assign head  = slots[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/gdt2_front.sv =====
module gdt2_front import gdt2_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  gdt2_in_t         item,
  input  logic             cfg_clear,
  input  logic [DIM_W-1:0] w_eff,
  input  logic [DIM_W-1:0] h_eff,
  input  logic             q_full,
  output logic             busy,
  output logic             push,
  output gdt2_cmd_t        push_cmd
);

  logic [CNT_W-1:0] load_count;
  logic [CNT_W-1:0] read_count;
  logic [IDX_W-1:0] row;
  logic             ready;
  logic [CNT_W-1:0] total;
  logic             accept;
  logic             do_load;
  logic             do_read;
  logic             load_fin;
  logic             read_fin;

  assign busy     = q_full;
  assign accept   = start && !q_full;
  assign total    = CNT_W'(w_eff) * CNT_W'(h_eff);
  assign do_load  = accept && (item.mode == MODE_LOAD) && !ready && (load_count < total);
  assign do_read  = accept && (item.mode == MODE_READ) && ready;
  assign load_fin = (load_count + CNT_W'(1)) == total;
  assign read_fin = (read_count + CNT_W'(1)) == total;

  always_comb begin
    push              = do_load || do_read;
    push_cmd.is_read  = do_read;
    push_cmd.flag     = do_read ? read_fin : load_fin;
    push_cmd.addr     = do_read ? read_count[MAP_AW-1:0] : load_count[MAP_AW-1:0];
    push_cmd.row      = row;
    push_cmd.score    = item.score;
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_clear) begin
      load_count <= '0;
      read_count <= '0;
      row        <= '0;
      ready      <= 1'b0;
    end else if (do_load) begin
      load_count <= load_count + 1'b1;
      if (load_fin) begin
        ready <= 1'b1;
      end
    end else if (do_read) begin
      if (read_fin) begin
        load_count <= '0;
        read_count <= '0;
        row        <= '0;
        ready      <= 1'b0;
      end else begin
        read_count <= read_count + 1'b1;
        row        <= (DIM_W'(row) == h_eff - DIM_W'(1)) ? '0 : row + 1'b1;
      end
    end
  end

endmodule

// ===== rtl/gdt2_back.sv =====
module gdt2_back import gdt2_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  gdt2_cmd_t        q_head,
  output logic             pop,
  input  logic [DIM_W-1:0] w_eff,
  input  logic [DIM_W-1:0] h_eff,
  input  gdt2_axis_t       x_axis,
  input  gdt2_axis_t       y_axis,
  output logic             result_valid,
  output gdt2_out_t        result
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_LSTART = 5'd1;
  localparam logic [4:0] S_QRD    = 5'd2;
  localparam logic [4:0] S_QFQ    = 5'd3;
  localparam logic [4:0] S_XRD    = 5'd4;
  localparam logic [4:0] S_XFV    = 5'd5;
  localparam logic [4:0] S_XMUL   = 5'd6;
  localparam logic [4:0] S_XNUM   = 5'd7;
  localparam logic [4:0] S_XCHK   = 5'd8;
  localparam logic [4:0] S_XDIV   = 5'd9;
  localparam logic [4:0] S_XDEC   = 5'd10;
  localparam logic [4:0] S_POP    = 5'd11;
  localparam logic [4:0] S_ENXT   = 5'd12;
  localparam logic [4:0] S_ECMP   = 5'd13;
  localparam logic [4:0] S_VRD    = 5'd14;
  localparam logic [4:0] S_VF     = 5'd15;
  localparam logic [4:0] S_VMUL   = 5'd16;
  localparam logic [4:0] S_VSUM   = 5'd17;
  localparam logic [4:0] S_R1     = 5'd18;
  localparam logic [4:0] S_R2     = 5'd19;

  localparam logic signed [BOUND_W-1:0] ONE_Q = BOUND_W'(1) <<< FRAC_BITS;
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  logic [4:0]                st;
  logic                      pass;
  logic [IDX_W-1:0]          line;
  logic [IDX_W-1:0]          q;
  logic [IDX_W-1:0]          top;
  logic [IDX_W-1:0]          k;
  logic [IDX_W-1:0]          tv;
  logic [IDX_W-1:0]          kv;
  logic signed [BOUND_W-1:0] tb;
  logic signed [BOUND_W-1:0] s;
  logic signed [VAL_W-1:0]   fq;
  logic signed [VAL_W-1:0]   fv;
  logic [IDX_W-1:0]          dq;
  logic [SQ_W-1:0]           sq;
  logic [SQ_W-1:0]           dd;
  logic signed [D_W-1:0]     d;
  logic [P1_W-1:0]           p1;
  logic signed [P2_W-1:0]    p2;
  logic [DEN_W-1:0]          den;
  logic [LDEN_W-1:0]         lden;
  logic signed [NUM_W-1:0]   num;
  logic [DIV_W-1:0]          rem;
  logic [DIV_W-1:0]          dsh;
  logic [QUOT_W-1:0]         quot;
  logic [QCNT_W-1:0]         qcnt;
  logic [IDX_W-1:0]          rd_row;
  logic                      rd_last;
  logic [IDX_W-1:0]          rd_col;
  logic signed [VAL_W-1:0]   rd_val;

  logic [DIM_W-1:0]          len;
  logic [DIM_W-1:0]          nlines;
  gdt2_axis_t                axis;
  logic [IDX_W-1:0]          pos;
  logic [IDX_W-1:0]          major;
  logic [IDX_W-1:0]          minor;
  logic [IDX_W+DIM_W-1:0]    major_prod;
  logic [MAP_AW-1:0]         lin_addr;
  logic [IDX_W-1:0]          col_clamp;
  logic [IDX_W+DIM_W-1:0]    col_prod;
  logic [MAP_AW-1:0]         rd_addr2;
  logic signed [VAL_W-1:0]   src_val;
  logic                      last_pos;
  logic                      line_last;
  logic                      rem_ge;
  logic [QUOT_W-1:0]         quot_next;
  logic signed [NUM_W-1:0]   num_plus;
  logic signed [NUM_W-1:0]   vsum;
  logic signed [VAL_W-1:0]   vsat;

  logic [SCORE_W-1:0]        in_rdata;
  gdt2_ent_t                 cp_rdata;
  gdt2_ent_t                 rs_rdata;
  gdt2_env_t                 env_rdata;
  logic                      cp_we;
  logic                      rs_we;
  logic                      env_we;
  logic [IDX_W-1:0]          env_waddr;
  gdt2_env_t                 env_wdata;
  logic [IDX_W-1:0]          env_raddr;
  logic [MAP_AW-1:0]         cp_raddr;
  gdt2_ent_t                 vs_ent;

  assign len    = pass ? w_eff : h_eff;
  assign nlines = pass ? h_eff : w_eff;
  assign axis   = pass ? x_axis : y_axis;
  assign pop    = (st == S_IDLE) && !q_empty;

  always_comb begin
    if (st == S_XRD) begin
      pos = tv;
    end else if (st == S_VRD) begin
      pos = kv;
    end else begin
      pos = q;
    end
    major      = pass ? pos : line;
    minor      = pass ? line : pos;
    major_prod = (IDX_W+DIM_W)'(major) * (IDX_W+DIM_W)'(h_eff);
    lin_addr   = major_prod[MAP_AW-1:0] + MAP_AW'(minor);

    col_clamp  = (DIM_W'(rs_rdata.idx) >= w_eff) ? IDX_W'(w_eff - DIM_W'(1)) : rs_rdata.idx;
    col_prod   = (IDX_W+DIM_W)'(col_clamp) * (IDX_W+DIM_W)'(h_eff);
    rd_addr2   = col_prod[MAP_AW-1:0] + MAP_AW'(rd_row);

    src_val    = pass ? cp_rdata.value : VAL_W'($signed(in_rdata));
    last_pos   = DIM_W'(q) == (len - DIM_W'(1));
    line_last  = DIM_W'(line) == (nlines - DIM_W'(1));

    rem_ge     = rem >= dsh;
    quot_next  = {quot[QUOT_W-2:0], rem_ge};
    num_plus   = num + $signed(NUM_W'(den));

    vsum = NUM_W'(fv) + $signed(NUM_W'(p1)) + NUM_W'(p2) + NUM_W'(axis.offset);
    if (vsum > NUM_W'(VAL_MAX)) begin
      vsat = VAL_MAX;
    end else if (vsum < NUM_W'(VAL_MIN)) begin
      vsat = VAL_MIN;
    end else begin
      vsat = vsum[VAL_W-1:0];
    end
    vs_ent.idx   = kv;
    vs_ent.value = vsat;

    cp_we    = (st == S_VSUM) && !pass;
    rs_we    = (st == S_VSUM) && pass;
    cp_raddr = (st == S_R1) ? rd_addr2 : lin_addr;

    env_we    = 1'b0;
    env_waddr = top + 1'b1;
    env_wdata.vertex = q;
    env_wdata.bound  = s;
    if (st == S_LSTART) begin
      env_we           = 1'b1;
      env_waddr        = '0;
      env_wdata.vertex = '0;
      env_wdata.bound  = -(ONE_Q <<< 1);
    end else if (st == S_XDEC && !(top != '0 && s <= tb)) begin
      env_we = 1'b1;
    end
    env_raddr = (st == S_XDEC) ? top - 1'b1 : k + 1'b1;
  end

  gdt2_ram #(.WIDTH(SCORE_W), .DEPTH(MAP_DEPTH)) u_in_ram (
    .clk   (clk),
    .we    (pop && !q_head.is_read),
    .waddr (q_head.addr),
    .wdata (q_head.score),
    .raddr (lin_addr),
    .rdata (in_rdata)
  );

  gdt2_ram #(.WIDTH($bits(gdt2_ent_t)), .DEPTH(MAP_DEPTH)) u_cp_ram (
    .clk   (clk),
    .we    (cp_we),
    .waddr (lin_addr),
    .wdata (vs_ent),
    .raddr (cp_raddr),
    .rdata (cp_rdata)
  );

  gdt2_ram #(.WIDTH($bits(gdt2_ent_t)), .DEPTH(MAP_DEPTH)) u_rs_ram (
    .clk   (clk),
    .we    (rs_we),
    .waddr (lin_addr),
    .wdata (vs_ent),
    .raddr (q_head.addr),
    .rdata (rs_rdata)
  );

  gdt2_ram #(.WIDTH($bits(gdt2_env_t)), .DEPTH(MAX_LINE)) u_env_ram (
    .clk   (clk),
    .we    (env_we),
    .waddr (env_waddr),
    .wdata (env_wdata),
    .raddr (env_raddr),
    .rdata (env_rdata)
  );

  always_ff @(posedge clk) begin
    case (st)
      S_QFQ: fq <= src_val;
      S_XFV: begin
        fv <= src_val;
        dq <= q - tv;
        sq <= SQ_W'(q) * SQ_W'(q) - SQ_W'(tv) * SQ_W'(tv);
      end
      S_XMUL: begin
        p1  <= P1_W'(axis.quad) * P1_W'(sq);
        p2  <= P2_W'(axis.linear) * P2_W'($signed({1'b0, dq}));
        den <= (DEN_W'(axis.quad) * DEN_W'(dq)) << 1;
      end
      S_XNUM: begin
        num  <= NUM_W'(fq) - NUM_W'(fv) + $signed(NUM_W'(p1)) - NUM_W'(p2);
        lden <= LDEN_W'(den) * LDEN_W'(len);
      end
      S_XCHK: begin
        rem  <= DIV_W'(num_plus[LDEN_W-1:0]) << FRAC_BITS;
        dsh  <= DIV_W'(den) << (QUOT_W - 1);
        quot <= '0;
        qcnt <= '0;
      end
      S_XDIV: begin
        if (rem_ge) begin
          rem <= rem - dsh;
        end
        dsh  <= dsh >> 1;
        quot <= quot_next;
        qcnt <= qcnt + 1'b1;
      end
      S_VF: begin
        fv <= src_val;
        d  <= $signed({1'b0, q}) - $signed({1'b0, kv});
        if (q >= kv) begin
          dd <= SQ_W'(q - kv) * SQ_W'(q - kv);
        end else begin
          dd <= SQ_W'(kv - q) * SQ_W'(kv - q);
        end
      end
      S_VMUL: begin
        p1 <= P1_W'(axis.quad) * P1_W'(dd);
        p2 <= P2_W'(axis.linear) * P2_W'(d);
      end
      default: ;
    endcase
    if (pop) begin
      rd_row  <= q_head.row;
      rd_last <= q_head.flag;
    end
    if (st == S_R1) begin
      rd_col <= col_clamp;
      rd_val <= rs_rdata.value;
    end
    if (st == S_R2) begin
      result.value     <= rd_val;
      result.col_index <= FIELD_W'(rd_col) + FIELD_W'(1);
      result.row_index <= FIELD_W'(cp_rdata.idx) + FIELD_W'(1);
      result.last      <= rd_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= S_IDLE;
      pass         <= 1'b0;
      line         <= '0;
      q            <= '0;
      top          <= '0;
      k            <= '0;
      tv           <= '0;
      kv           <= '0;
      tb           <= '0;
      s            <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= (st == S_R2);
      unique case (st)
        S_IDLE: begin
          if (pop) begin
            if (q_head.is_read) begin
              st <= S_R1;
            end else if (q_head.flag) begin
              pass <= 1'b0;
              line <= '0;
              st   <= S_LSTART;
            end
          end
        end
        S_LSTART: begin
          top <= '0;
          tv  <= '0;
          tb  <= -(ONE_Q <<< 1);
          if (len == DIM_W'(1)) begin
            q  <= '0;
            k  <= '0;
            kv <= '0;
            st <= S_ENXT;
          end else begin
            q  <= IDX_W'(1);
            st <= S_QRD;
          end
        end
        S_QRD:  st <= S_QFQ;
        S_QFQ:  st <= S_XRD;
        S_XRD:  st <= S_XFV;
        S_XFV:  st <= S_XMUL;
        S_XMUL: st <= S_XNUM;
        S_XNUM: st <= S_XCHK;
        S_XCHK: begin
          if (num >= $signed(NUM_W'(lden))) begin
            s  <= BOUND_W'(len) <<< FRAC_BITS;
            st <= S_XDEC;
          end else if (num < -$signed(NUM_W'(den))) begin
            s  <= -ONE_Q;
            st <= S_XDEC;
          end else begin
            st <= S_XDIV;
          end
        end
        S_XDIV: begin
          if (qcnt == QCNT_W'(QUOT_W - 1)) begin
            s  <= $signed(BOUND_W'(quot_next)) - ONE_Q;
            st <= S_XDEC;
          end
        end
        S_XDEC: begin
          if (top != '0 && s <= tb) begin
            top <= top - 1'b1;
            st  <= S_POP;
          end else begin
            top <= top + 1'b1;
            tv  <= q;
            tb  <= s;
            if (last_pos) begin
              q  <= '0;
              k  <= '0;
              kv <= '0;
              st <= S_ENXT;
            end else begin
              q  <= q + 1'b1;
              st <= S_QRD;
            end
          end
        end
        S_POP: begin
          tv <= env_rdata.vertex;
          tb <= env_rdata.bound;
          st <= S_XRD;
        end
        S_ENXT: st <= (k == top) ? S_VRD : S_ECMP;
        S_ECMP: begin
          if (env_rdata.bound < ($signed(BOUND_W'(q)) <<< FRAC_BITS)) begin
            k  <= k + 1'b1;
            kv <= env_rdata.vertex;
            st <= S_ENXT;
          end else begin
            st <= S_VRD;
          end
        end
        S_VRD:  st <= S_VF;
        S_VF:   st <= S_VMUL;
        S_VMUL: st <= S_VSUM;
        S_VSUM: begin
          if (!last_pos) begin
            q  <= q + 1'b1;
            st <= S_ENXT;
          end else if (!line_last) begin
            line <= line + 1'b1;
            st   <= S_LSTART;
          end else if (!pass) begin
            pass <= 1'b1;
            line <= '0;
            st   <= S_LSTART;
          end else begin
            st <= S_IDLE;
          end
        end
        S_R1: st <= S_R2;
        S_R2: st <= S_IDLE;
        default: st <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/generalized_distance_transform_2d.sv =====
// 2d distance transform over a lower envelope of parabolas, q16 fixed point.
// input transactions: start with item.mode/item.score, taken when busy is low.
// mode load writes the next score of the map (column-major); the last score
// of the map starts the transform, first down each column, then along rows.
// mode read returns the next result (column-major) as one result_valid pulse
// carrying value, 1-based col_index/row_index of the source, and last.
// loads go into the input map when the back end pops them; the back end
// pops a read only when idle, runs S_R1 and S_R2, and registers its result.
// during the transform each envelope crossing uses a bit-serial divider,
// skipped when the crossing is clamped, and each output point follows an
// envelope walk, on each of the two passes; a 4-entry command queue lets
// start traffic continue meanwhile and busy rises only when that queue is
// full.
// reads before the map is complete and loads past the map are dropped.
// reset clears counters, the queue and the sequencer; config registers go
// to 64x64, unit quadratic weights, zero linear and constant terms.
// any config write drops a partial map. results cannot be held off.
module generalized_distance_transform_2d import gdt2_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  gdt2_in_t          item,
  input  logic              cfg_wr_en,
  input  logic [CFG_AW-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  output logic              result_valid,
  output gdt2_out_t         result
);

  logic [FIELD_W-1:0]       width_in_use;
  logic [FIELD_W-1:0]       height_in_use;
  logic [QUAD_W-1:0]        x_quad_coeff;
  logic signed [COEF_W-1:0] x_linear_coeff;
  logic signed [COEF_W-1:0] x_const_offset;
  logic [QUAD_W-1:0]        y_quad_coeff;
  logic signed [COEF_W-1:0] y_linear_coeff;
  logic signed [COEF_W-1:0] y_const_offset;

  logic [DIM_W-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;
  gdt2_axis_t       x_axis;
  gdt2_axis_t       y_axis;
  logic             q_full;
  logic             q_empty;
  logic             push;
  logic             pop;
  gdt2_cmd_t        push_cmd;
  gdt2_cmd_t        q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_in_use   <= FIELD_W'(64);
      height_in_use  <= FIELD_W'(64);
      x_quad_coeff   <= QUAD_W'(65536);
      x_linear_coeff <= '0;
      x_const_offset <= '0;
      y_quad_coeff   <= QUAD_W'(65536);
      y_linear_coeff <= '0;
      y_const_offset <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_WIDTH_IN_USE:  width_in_use   <= cfg_data[FIELD_W-1:0];
        REG_HEIGHT_IN_USE: height_in_use  <= cfg_data[FIELD_W-1:0];
        REG_X_QUAD:        x_quad_coeff   <= cfg_data[QUAD_W-1:0];
        REG_X_LINEAR:      x_linear_coeff <= cfg_data;
        REG_X_CONST:       x_const_offset <= cfg_data;
        REG_Y_QUAD:        y_quad_coeff   <= cfg_data[QUAD_W-1:0];
        REG_Y_LINEAR:      y_linear_coeff <= cfg_data;
        REG_Y_CONST:       y_const_offset <= cfg_data;
      endcase
    end
  end

  always_comb begin
    if (width_in_use == '0) begin
      w_eff = DIM_W'(1);
    end else if (DIM_W'(width_in_use) > DIM_W'(MAX_WIDTH)) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = DIM_W'(width_in_use);
    end
    if (height_in_use == '0) begin
      h_eff = DIM_W'(1);
    end else if (DIM_W'(height_in_use) > DIM_W'(MAX_HEIGHT)) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = DIM_W'(height_in_use);
    end
    x_axis.quad   = (x_quad_coeff == '0) ? QUAD_W'(1) : x_quad_coeff;
    x_axis.linear = x_linear_coeff;
    x_axis.offset = x_const_offset;
    y_axis.quad   = (y_quad_coeff == '0) ? QUAD_W'(1) : y_quad_coeff;
    y_axis.linear = y_linear_coeff;
    y_axis.offset = y_const_offset;
  end

  gdt2_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (item),
    .cfg_clear (cfg_wr_en),
    .w_eff     (w_eff),
    .h_eff     (h_eff),
    .q_full    (q_full),
    .busy      (busy),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  gdt2_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .empty    (q_empty),
    .full     (q_full),
    .head     (q_head)
  );

  gdt2_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .pop          (pop),
    .w_eff        (w_eff),
    .h_eff        (h_eff),
    .x_axis       (x_axis),
    .y_axis       (y_axis),
    .result_valid (result_valid),
    .result       (result)
  );

  a_result_gap: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("results on consecutive cycles");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.col_index != '0) && (result.row_index != '0) &&
                     (DIM_W'(result.col_index) <= w_eff))
    else $error("result index out of range");

  a_queue_order: assert property (@(posedge clk) disable iff (rst)
    push && q_full |-> pop)
    else $error("queue overflow");

endmodule

// ===== sim/tb.sv =====
module tb;
  import gdt2_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 100000;
  localparam int SETTLE_CYCLES = 60;
  localparam longint VAL_MAX = (longint'(1) <<< 47) - 1;
  localparam longint VAL_MIN = -(longint'(1) <<< 47);
  localparam longint ONE_Q = longint'(1) <<< FRAC_BITS;

  class distance_scoreboard;
    logic [6:0]  width_reg, height_reg;
    logic [30:0] x_quad, y_quad;
    logic [31:0] x_lin, x_off, y_lin, y_off;
    longint in_map[MAP_DEPTH];
    longint col_val[MAP_DEPTH];
    int     col_row[MAP_DEPTH];
    longint res_val[MAP_DEPTH];
    int     res_col[MAP_DEPTH];
    longint line_src[MAX_LINE];
    longint line_val[MAX_LINE];
    int     line_idx[MAX_LINE];
    int     env_vertex[MAX_LINE];
    longint env_bound[MAX_LINE + 1];
    int     loads, reads;
    bit     ready;
    gdt2_out_t pending[$];
    int     errors;

    function new();
      width_reg = 64;
      height_reg = 64;
      x_quad = 65536;
      y_quad = 65536;
      x_lin = 0;
      x_off = 0;
      y_lin = 0;
      y_off = 0;
      loads = 0;
      reads = 0;
      ready = 0;
      errors = 0;
    endfunction

    function int dim_of(logic [6:0] r);
      if (r == 0) return 1;
      if (r > 64) return 64;
      return int'(r);
    endfunction

    function longint sat_val(longint v);
      if (v > VAL_MAX) return VAL_MAX;
      if (v < VAL_MIN) return VAL_MIN;
      return v;
    endfunction

    function longint crossing(int q, int v, int len, longint a, longint b);
      longint dq, num, den, qt, rem, frac;
      dq = longint'(q) - v;
      num = line_src[q] - line_src[v] + a * (longint'(q) * q - longint'(v) * v) - b * dq;
      den = 2 * a * dq;
      qt = num / den;
      rem = num % den;
      frac = 0;
      if (rem < 0) begin
        qt -= 1;
        rem += den;
      end
      if (qt >= len) return longint'(len) * ONE_Q;
      if (qt < -1) return -ONE_Q;
      for (int i = 0; i < FRAC_BITS; i++) begin
        rem *= 2;
        frac *= 2;
        if (rem >= den) begin
          rem -= den;
          frac += 1;
        end
      end
      return qt * ONE_Q + frac;
    endfunction

    function void lower_envelope(int len, longint a, longint b, longint c);
      int k, v;
      longint s, d;
      k = 0;
      env_vertex[0] = 0;
      env_bound[0] = -2 * ONE_Q;
      env_bound[1] = longint'(len + 1) * ONE_Q;
      for (int q = 1; q < len; q++) begin
        s = crossing(q, env_vertex[k], len, a, b);
        while (k > 0 && s <= env_bound[k]) begin
          k--;
          s = crossing(q, env_vertex[k], len, a, b);
        end
        k++;
        env_vertex[k] = q;
        env_bound[k] = s;
        env_bound[k + 1] = longint'(len + 1) * ONE_Q;
      end
      k = 0;
      for (int q = 0; q < len; q++) begin
        while (env_bound[k + 1] < longint'(q) * ONE_Q) k++;
        v = env_vertex[k];
        d = longint'(q) - v;
        line_val[q] = sat_val(line_src[v] + a * d * d + b * d + c);
        line_idx[q] = v;
      end
    endfunction

    function void transform(int w, int h);
      longint ya, xa;
      ya = (y_quad == 0) ? 1 : longint'(y_quad);
      xa = (x_quad == 0) ? 1 : longint'(x_quad);
      for (int x = 0; x < w; x++) begin
        for (int y = 0; y < h; y++) line_src[y] = in_map[x * h + y];
        lower_envelope(h, ya, longint'($signed(y_lin)), longint'($signed(y_off)));
        for (int y = 0; y < h; y++) begin
          col_val[x * h + y] = line_val[y];
          col_row[x * h + y] = line_idx[y];
        end
      end
      for (int y = 0; y < h; y++) begin
        for (int x = 0; x < w; x++) line_src[x] = col_val[x * h + y];
        lower_envelope(w, xa, longint'($signed(x_lin)), longint'($signed(x_off)));
        for (int x = 0; x < w; x++) begin
          res_val[x * h + y] = line_val[x];
          res_col[x * h + y] = line_idx[x];
        end
      end
    endfunction

    function void write_reg(logic [CFG_AW-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_WIDTH_IN_USE:  width_reg = data[6:0];
        REG_HEIGHT_IN_USE: height_reg = data[6:0];
        REG_X_QUAD:        x_quad = data[30:0];
        REG_X_LINEAR:      x_lin = data;
        REG_X_CONST:       x_off = data;
        REG_Y_QUAD:        y_quad = data[30:0];
        REG_Y_LINEAR:      y_lin = data;
        REG_Y_CONST:       y_off = data;
        default: ;
      endcase
      loads = 0;
      reads = 0;
      ready = 0;
    endfunction

    function void note_item(gdt2_in_t it);
      int w, h, total, col, y;
      gdt2_out_t r;
      w = dim_of(width_reg);
      h = dim_of(height_reg);
      total = w * h;
      if (it.mode == MODE_LOAD) begin
        if (ready || loads >= total) return;
        in_map[loads] = longint'(it.score);
        loads++;
        if (loads == total) begin
          transform(w, h);
          ready = 1;
        end
      end else begin
        if (!ready || reads >= total) return;
        y = reads % h;
        col = res_col[reads];
        if (col >= w) col = w - 1;
        r.value = res_val[reads][47:0];
        r.col_index = 7'(col + 1);
        r.row_index = 7'(col_row[col * h + y] + 1);
        reads++;
        r.last = (reads == total);
        if (r.last) begin
          loads = 0;
          reads = 0;
          ready = 0;
        end
        pending.insert(pending.size(), r);
      end
    endfunction

    function void check_result(gdt2_out_t got);
      gdt2_out_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transaction %p", got);
        return;
      end
      want = pending.pop_front();
      if (got.value !== want.value || got.col_index !== want.col_index ||
          got.row_index !== want.row_index || got.last !== want.last) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: value %0d/%0d col %0d/%0d row %0d/%0d last %0b/%0b (exp/act)",
                   want.value, got.value, want.col_index, got.col_index,
                   want.row_index, got.row_index, want.last, got.last);
      end
    endfunction
  endclass

  logic              clk = 0;
  logic              rst = 1;
  logic              start = 0;
  logic              busy;
  gdt2_in_t          item = '0;
  logic              cfg_wr_en = 0;
  logic [CFG_AW-1:0] cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data = '0;
  logic              result_valid;
  gdt2_out_t         result;

  distance_scoreboard sb = new();
  int accepted = 0;
  int quiet = 0;
  int items_sent = 0;
  int idle_pct = 0;

  generalized_distance_transform_2d u_dut (
    .clk, .rst, .start, .busy, .item, .cfg_wr_en, .cfg_index, .cfg_data,
    .result_valid, .result
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid) sb.check_result(result);
      if (cfg_wr_en) sb.write_reg(cfg_index, cfg_data);
      if (start && !busy) begin
        sb.note_item(item);
        accepted++;
      end
      if ((start && !busy) || result_valid) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("tb: errors");
        $finish;
      end
    end
  end

  task automatic send(logic mode, logic [31:0] score);
    int n;
    if ($urandom_range(99) < idle_pct) begin
      start = 0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    start = 1;
    item.mode = mode;
    item.score = score;
    n = accepted;
    do @(negedge clk); while (accepted == n);
    start = 0;
    items_sent++;
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_W-1:0] data);
    cfg_wr_en = 1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_wr_en = 0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_score();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 2 << 20)) - (1 << 20));
      2: case ($urandom_range(3))
           0: return 32'h7fff_ffff;
           1: return 32'h8000_0000;
           2: return 32'h0;
           default: return 32'hffff_ffff;
         endcase
      default: return 32'($signed($urandom_range(0, 2 << 24)) - (1 << 24));
    endcase
  endfunction

  function automatic logic [31:0] rand_quad();
    case ($urandom_range(4))
      0: return 32'h0;
      1: return 32'h1;
      2: return 32'h7fff_ffff | ($urandom & 32'h8000_0000);
      3: return $urandom & 32'h7fff_ffff;
      default: return $urandom_range(1, 1 << 18);
    endcase
  endfunction

  function automatic logic [31:0] rand_coeff();
    case ($urandom_range(4))
      0: return 32'h0;
      1: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      2: return $urandom;
      default: return 32'($signed($urandom_range(0, 2 << 18)) - (1 << 18));
    endcase
  endfunction

  task automatic write_all(logic [6:0] wr, logic [6:0] hr);
    write_reg(REG_WIDTH_IN_USE, {$urandom_range(1) ? $urandom : 32'h0} & ~32'h7f | wr);
    write_reg(REG_HEIGHT_IN_USE, {$urandom_range(1) ? $urandom : 32'h0} & ~32'h7f | hr);
    write_reg(REG_X_QUAD, rand_quad());
    write_reg(REG_X_LINEAR, rand_coeff());
    write_reg(REG_X_CONST, rand_coeff());
    write_reg(REG_Y_QUAD, rand_quad());
    write_reg(REG_Y_LINEAR, rand_coeff());
    write_reg(REG_Y_CONST, rand_coeff());
  endtask

  task automatic run_map(logic [6:0] wr, logic [6:0] hr, bit noise);
    int total;
    write_all(wr, hr);
    total = sb.dim_of(wr) * sb.dim_of(hr);
    if (noise && total > 1 && $urandom_range(7) == 0) begin
      repeat ($urandom_range(1, total - 1)) send(MODE_LOAD, rand_score());
      repeat (SETTLE_CYCLES) @(negedge clk);
      write_all(wr, hr);
    end
    if (noise) repeat ($urandom_range(0, 2)) send(MODE_READ, $urandom);
    for (int i = 0; i < total; i++) begin
      send(MODE_LOAD, rand_score());
      if (noise && $urandom_range(15) == 0) send(MODE_READ, $urandom);
    end
    if (noise) repeat ($urandom_range(0, 2)) send(MODE_LOAD, rand_score());
    for (int i = 0; i < total; i++) send(MODE_READ, $urandom);
    drain();
  endtask

  initial begin
    int wr, hr;
    repeat (11) @(negedge clk);
    rst = 0;
    @(negedge clk);

    // 2x2 map with extreme scores, read before ready and load after full
    write_reg(REG_WIDTH_IN_USE, 2);
    write_reg(REG_HEIGHT_IN_USE, 2);
    write_reg(REG_X_QUAD, 32'h0001_0000);
    write_reg(REG_X_LINEAR, 0);
    write_reg(REG_X_CONST, 0);
    write_reg(REG_Y_QUAD, 32'h0000_0001);
    write_reg(REG_Y_LINEAR, 32'h8000_0000);
    write_reg(REG_Y_CONST, 32'h7fff_ffff);
    send(MODE_READ, 0);
    send(MODE_LOAD, 32'h7fff_ffff);
    send(MODE_LOAD, 32'h8000_0000);
    send(MODE_READ, 0);
    send(MODE_LOAD, 32'h0);
    send(MODE_LOAD, 32'hffff_ffff);
    send(MODE_LOAD, 32'h1234_5678);
    repeat (4) send(MODE_READ, 32'hffff_ffff);
    send(MODE_READ, 0);
    drain();

    // 1x1 map, zero size registers and a zero x quadratic weight register
    write_reg(REG_WIDTH_IN_USE, 0);
    write_reg(REG_HEIGHT_IN_USE, 0);
    write_reg(REG_X_QUAD, 0);
    write_reg(REG_Y_QUAD, 32'hffff_ffff);
    write_reg(REG_X_LINEAR, 32'h7fff_ffff);
    write_reg(REG_X_CONST, 32'h8000_0000);
    send(MODE_LOAD, 32'h8000_0000);
    send(MODE_LOAD, 32'h7fff_ffff);
    send(MODE_READ, 0);
    drain();

    run_map(7'd127, 7'd1, 0);
    run_map(7'd1, 7'd64, 0);

    while (items_sent < 1000) begin
      if (items_sent < 420) idle_pct = 9;
      else if (items_sent < 720) idle_pct = 77;
      else idle_pct = 0;
      wr = $urandom_range(0, 5) == 0 ? $urandom_range(0, 127) % 10 : $urandom_range(1, 6);
      hr = $urandom_range(1, 6);
      run_map(7'(wr), 7'(hr), 1);
    end

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/gdt2_pkg.sv
rtl/gdt2_ram.sv
rtl/gdt2_queue.sv
rtl/gdt2_front.sv
rtl/gdt2_back.sv
rtl/generalized_distance_transform_2d.sv
sim/tb.sv
